[hdl/wav_header_parser_macros.svh]
// Assertion macros used by the header parser controller
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define WAVHP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define WAVHP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/wavhp_pkg.sv]
// Shared constants, types and decode functions of the WAV header parser
`default_nettype none

package wavhp_pkg;

	localparam int PHASE_W = 5;
	localparam int IDX_W   = 5;

	localparam logic [PHASE_W-1:0] PH_RIFF_ID    = 5'd0;
	localparam logic [PHASE_W-1:0] PH_RIFF_SIZE  = 5'd1;
	localparam logic [PHASE_W-1:0] PH_WAVE_ID    = 5'd2;
	localparam logic [PHASE_W-1:0] PH_FMT_ID     = 5'd3;
	localparam logic [PHASE_W-1:0] PH_FMT_SIZE   = 5'd4;
	localparam logic [PHASE_W-1:0] PH_TAG        = 5'd5;
	localparam logic [PHASE_W-1:0] PH_CHAN       = 5'd6;
	localparam logic [PHASE_W-1:0] PH_RATE       = 5'd7;
	localparam logic [PHASE_W-1:0] PH_AVG        = 5'd8;
	localparam logic [PHASE_W-1:0] PH_ALIGN      = 5'd9;
	localparam logic [PHASE_W-1:0] PH_BITS       = 5'd10;
	localparam logic [PHASE_W-1:0] PH_CBSIZE     = 5'd11;
	localparam logic [PHASE_W-1:0] PH_VALID      = 5'd12;
	localparam logic [PHASE_W-1:0] PH_MASK       = 5'd13;
	localparam logic [PHASE_W-1:0] PH_SUBFMT     = 5'd14;
	localparam logic [PHASE_W-1:0] PH_FIRST_ID   = 5'd15;
	localparam logic [PHASE_W-1:0] PH_FACT_SIZE  = 5'd16;
	localparam logic [PHASE_W-1:0] PH_FACT_LEN   = 5'd17;
	localparam logic [PHASE_W-1:0] PH_CHUNK_ID   = 5'd18;
	localparam logic [PHASE_W-1:0] PH_CHUNK_SIZE = 5'd19;
	localparam logic [PHASE_W-1:0] PH_SKIP       = 5'd20;
	localparam logic [PHASE_W-1:0] PH_DATA_SIZE  = 5'd21;
	localparam logic [PHASE_W-1:0] PH_DONE       = 5'd22;

	localparam logic [3:0] ST_NONE       = 4'd0;
	localparam logic [3:0] ST_FMT_SIZE   = 4'd1;
	localparam logic [3:0] ST_TAG        = 4'd2;
	localparam logic [3:0] ST_CHAN       = 4'd3;
	localparam logic [3:0] ST_RATE       = 4'd4;
	localparam logic [3:0] ST_ALIGN      = 4'd5;
	localparam logic [3:0] ST_BITS       = 4'd6;
	localparam logic [3:0] ST_SUBFMT     = 4'd7;
	localparam logic [3:0] ST_FACT_SIZE  = 4'd8;
	localparam logic [3:0] ST_SKIP_CHUNK = 4'd9;
	localparam logic [3:0] ST_SKIP_FACT  = 4'd10;
	localparam logic [3:0] ST_FACT_SEEN  = 4'd11;

	localparam logic [31:0] TAG_FACT        = 32'h7463_6166;
	localparam logic [31:0] TAG_DATA        = 32'h6174_6164;
	localparam logic [31:0] FMT_SIZE_EXT    = 32'd18;
	localparam logic [31:0] FMT_SIZE_WAVEX  = 32'd40;
	localparam logic [31:0] FACT_BASE_BYTES = 32'd4;

	localparam logic [15:0] FMT_FLOAT   = 16'h0003;
	localparam logic [15:0] FMT_PCM     = 16'h0001;
	localparam logic [15:0] FMT_WAVEX   = 16'hFFFE;
	localparam logic [15:0] SUBFMT_FLOAT = 16'h0003;
	localparam logic [15:0] SUBFMT_PCM   = 16'h0001;
	localparam logic [15:0] BITS_16     = 16'd16;
	localparam logic [15:0] BITS_24     = 16'd24;

	localparam logic [2:0] KIND_FLOAT32     = 3'd0;
	localparam logic [2:0] KIND_PCM16       = 3'd1;
	localparam logic [2:0] KIND_PCM24       = 3'd2;
	localparam logic [2:0] KIND_PCM_OTHER   = 3'd3;
	localparam logic [2:0] KIND_UNSUPPORTED = 3'd4;

	typedef struct packed {
		logic             clear;
		logic             count;
		logic             take;
		logic [IDX_W-1:0] byte_idx;
		logic             word_end;
		logic [3:0]       store;
		logic             skip_dec;
		logic             div_start;
	} cmd_t;

	typedef struct packed {
		logic is_fact;
		logic is_data;
		logic word_zero;
		logic fmt_ext;
		logic fmt_wavex;
		logic fact_long;
		logic skip_last;
		logic div_done;
	} stat_t;

	function automatic logic [IDX_W-1:0] field_len(input logic [PHASE_W-1:0] ph);
		logic [IDX_W-1:0] len;
		unique case (ph) inside
			PH_TAG, PH_CHAN, PH_ALIGN, PH_BITS, PH_CBSIZE, PH_VALID: len = 5'd2;
			PH_SUBFMT: len = 5'd16;
			PH_SKIP:   len = 5'd0;
			default:   len = 5'd4;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] sample_kind(input logic [15:0] tag,
			input logic [15:0] bits, input logic [15:0] subfmt);
		logic [2:0] pcm;
		logic [2:0] kind;
		if (bits == BITS_16) begin
			pcm = KIND_PCM16;
		end else if (bits == BITS_24) begin
			pcm = KIND_PCM24;
		end else begin
			pcm = KIND_PCM_OTHER;
		end
		if (tag == FMT_FLOAT) begin
			kind = KIND_FLOAT32;
		end else if (tag == FMT_PCM) begin
			kind = pcm;
		end else if (tag == FMT_WAVEX && subfmt == SUBFMT_FLOAT) begin
			kind = KIND_FLOAT32;
		end else if (tag == FMT_WAVEX && subfmt == SUBFMT_PCM) begin
			kind = pcm;
		end else begin
			kind = KIND_UNSUPPORTED;
		end
		return kind;
	endfunction

endpackage

`default_nettype wire

[hdl/wav_header_parser.sv]
// The last byte of the data chunk size starts the frame-count divide, whose done
// strobe registers frame_count and out_valid. Throughput: one byte per cycle; input
// stalls only during the divide and while a finished result waits and the next file
// reaches its data size. The divide is a restoring divider, one quotient bit per cycle.
// Reset: arst_n clears all parse state; parsing restarts at the RIFF tag.
// Top level: WAV header parser with byte-stream input and one result per file
`default_nettype none

module wav_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        start_of_file,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      format_tag,
	output logic [15:0]      channel_count,
	output logic [31:0]      sample_rate,
	output logic [15:0]      block_align,
	output logic [15:0]      bits_per_sample,
	output logic [31:0]      data_size,
	output logic [31:0]      frame_count,
	output logic [31:0]      header_length,
	output logic             fact_present,
	output logic [2:0]       sample_kind,
	output logic             zero_block_align
);

	wavhp_pkg::cmd_t  cmd;
	wavhp_pkg::stat_t stat;

	wavhp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	wavhp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_value       (byte_value),
		.cmd              (cmd),
		.stat             (stat),
		.format_tag       (format_tag),
		.channel_count    (channel_count),
		.sample_rate      (sample_rate),
		.block_align      (block_align),
		.bits_per_sample  (bits_per_sample),
		.data_size        (data_size),
		.frame_count      (frame_count),
		.header_length    (header_length),
		.fact_present     (fact_present),
		.sample_kind      (sample_kind),
		.zero_block_align (zero_block_align)
	);

endmodule

`default_nettype wire

[hdl/wavhp_div.sv]
// Restoring divider, one quotient bit per cycle, for the frame count
`default_nettype none

module wavhp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[hdl/wavhp_dp.sv]
// Datapath: byte assembly, header field registers, skip counter and result register
`default_nettype none

module wavhp_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           byte_value,
	input  wire wavhp_pkg::cmd_t      cmd,
	output wavhp_pkg::stat_t          stat,
	output logic [15:0]               format_tag,
	output logic [15:0]               channel_count,
	output logic [31:0]               sample_rate,
	output logic [15:0]               block_align,
	output logic [15:0]               bits_per_sample,
	output logic [31:0]               data_size,
	output logic [31:0]               frame_count,
	output logic [31:0]               header_length,
	output logic                      fact_present,
	output logic [2:0]                sample_kind,
	output logic                      zero_block_align
);

	logic [31:0] word_q;
	logic [31:0] fmt_size_q;
	logic [15:0] tag_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] align_q;
	logic [15:0] bits_q;
	logic [15:0] subfmt_q;
	logic [31:0] skip_q;
	logic [31:0] fact_size_q;
	logic [31:0] count_q;
	logic        fact_seen_q;

	logic [15:0] format_tag_q;
	logic [15:0] channel_count_q;
	logic [31:0] sample_rate_q;
	logic [15:0] block_align_q;
	logic [15:0] bits_per_sample_q;
	logic [31:0] data_size_q;
	logic [31:0] frame_count_q;
	logic [31:0] header_length_q;
	logic        fact_present_q;
	logic [2:0]  sample_kind_q;
	logic        zero_block_align_q;

	logic [31:0] word_base;
	logic [31:0] byte_shift;
	logic [31:0] word_now;
	logic [31:0] count_base;
	logic [31:0] count_inc;
	logic        div_done;
	logic [31:0] quotient;

	assign word_base  = cmd.clear ? '0 : word_q;
	assign byte_shift = (cmd.byte_idx[4:2] == 3'd0) ?
		({24'd0, byte_value} << {cmd.byte_idx[1:0], 3'b000}) : '0;
	assign word_now   = word_base | byte_shift;
	assign count_base = cmd.clear ? '0 : count_q;
	assign count_inc  = (&count_base) ? count_base : count_base + 32'd1;

	always_comb begin
		stat.is_fact   = word_now == wavhp_pkg::TAG_FACT;
		stat.is_data   = word_now == wavhp_pkg::TAG_DATA;
		stat.word_zero = word_now == '0;
		stat.fmt_ext   = fmt_size_q == wavhp_pkg::FMT_SIZE_EXT ||
			fmt_size_q == wavhp_pkg::FMT_SIZE_WAVEX;
		stat.fmt_wavex = fmt_size_q == wavhp_pkg::FMT_SIZE_WAVEX;
		stat.fact_long = fact_size_q > wavhp_pkg::FACT_BASE_BYTES;
		stat.skip_last = skip_q == 32'd1;
		stat.div_done  = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			fmt_size_q  <= '0;
			tag_q       <= '0;
			chan_q      <= '0;
			rate_q      <= '0;
			align_q     <= '0;
			bits_q      <= '0;
			subfmt_q    <= '0;
			skip_q      <= '0;
			fact_size_q <= '0;
			count_q     <= '0;
			fact_seen_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				word_q      <= '0;
				fmt_size_q  <= '0;
				tag_q       <= '0;
				chan_q      <= '0;
				rate_q      <= '0;
				align_q     <= '0;
				bits_q      <= '0;
				subfmt_q    <= '0;
				skip_q      <= '0;
				fact_size_q <= '0;
				count_q     <= '0;
				fact_seen_q <= 1'b0;
			end
			if (cmd.count) begin
				count_q <= count_inc;
			end
			if (cmd.take) begin
				word_q <= cmd.word_end ? '0 : word_now;
			end
			if (cmd.skip_dec) begin
				skip_q <= skip_q - 32'd1;
			end
			case (cmd.store)
				wavhp_pkg::ST_FMT_SIZE:   fmt_size_q  <= word_now;
				wavhp_pkg::ST_TAG:        tag_q       <= word_now[15:0];
				wavhp_pkg::ST_CHAN:       chan_q      <= word_now[15:0];
				wavhp_pkg::ST_RATE:       rate_q      <= word_now;
				wavhp_pkg::ST_ALIGN:      align_q     <= word_now[15:0];
				wavhp_pkg::ST_BITS:       bits_q      <= word_now[15:0];
				wavhp_pkg::ST_SUBFMT:     subfmt_q    <= word_now[15:0];
				wavhp_pkg::ST_FACT_SIZE:  fact_size_q <= word_now;
				wavhp_pkg::ST_SKIP_CHUNK: skip_q      <= word_now;
				wavhp_pkg::ST_SKIP_FACT:  skip_q      <= fact_size_q - wavhp_pkg::FACT_BASE_BYTES;
				wavhp_pkg::ST_FACT_SEEN:  fact_seen_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			format_tag_q       <= tag_q;
			channel_count_q    <= chan_q;
			sample_rate_q      <= rate_q;
			block_align_q      <= align_q;
			bits_per_sample_q  <= bits_q;
			data_size_q        <= word_now;
			header_length_q    <= count_inc;
			fact_present_q     <= fact_seen_q;
			sample_kind_q      <= wavhp_pkg::sample_kind(tag_q, bits_q, subfmt_q);
			zero_block_align_q <= align_q == '0;
		end
		if (div_done) begin
			frame_count_q <= zero_block_align_q ? '0 : quotient;
		end
	end

	wavhp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (word_now),
		.divisor  (align_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign format_tag       = format_tag_q;
	assign channel_count    = channel_count_q;
	assign sample_rate      = sample_rate_q;
	assign block_align      = block_align_q;
	assign bits_per_sample  = bits_per_sample_q;
	assign data_size        = data_size_q;
	assign frame_count      = frame_count_q;
	assign header_length    = header_length_q;
	assign fact_present     = fact_present_q;
	assign sample_kind      = sample_kind_q;
	assign zero_block_align = zero_block_align_q;

endmodule

`default_nettype wire

[hdl/wavhp_ctrl.sv]
// Controller: parse phase sequencer, byte handshake and result handshake
`default_nettype none

`include "wav_header_parser_macros.svh"

module wavhp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             start_of_file,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire wavhp_pkg::stat_t stat,
	output wavhp_pkg::cmd_t       cmd
);

	logic [wavhp_pkg::PHASE_W-1:0] phase_q;
	logic [wavhp_pkg::PHASE_W-1:0] phase_d;
	logic [wavhp_pkg::IDX_W-1:0]   idx_q;
	logic [wavhp_pkg::IDX_W-1:0]   idx_d;
	logic                          div_busy_q;
	logic                          out_valid_q;

	logic [wavhp_pkg::PHASE_W-1:0] ph_base;
	logic [wavhp_pkg::IDX_W-1:0]   ix_base;
	logic [wavhp_pkg::IDX_W-1:0]   ix_next;
	logic                          acc;

	assign in_ready = !div_busy_q && !(out_valid_q && phase_q == wavhp_pkg::PH_DATA_SIZE);
	assign acc      = in_valid && in_ready;
	assign ph_base  = start_of_file ? wavhp_pkg::PH_RIFF_ID : phase_q;
	assign ix_base  = start_of_file ? '0 : idx_q;
	assign ix_next  = ix_base + 5'd1;

	always_comb begin
		cmd      = '0;
		phase_d  = phase_q;
		idx_d    = idx_q;
		if (acc) begin
			cmd.clear = start_of_file;
			phase_d   = ph_base;
			idx_d     = ix_base;
			if (ph_base == wavhp_pkg::PH_SKIP) begin
				cmd.count    = 1'b1;
				cmd.skip_dec = 1'b1;
				if (stat.skip_last) begin
					phase_d = wavhp_pkg::PH_CHUNK_ID;
				end
			end else if (ph_base != wavhp_pkg::PH_DONE) begin
				cmd.count    = 1'b1;
				cmd.take     = 1'b1;
				cmd.byte_idx = ix_base;
				if (ix_next == wavhp_pkg::field_len(ph_base)) begin
					cmd.word_end = 1'b1;
					idx_d        = '0;
					unique case (ph_base)
						wavhp_pkg::PH_FMT_SIZE: begin
							cmd.store = wavhp_pkg::ST_FMT_SIZE;
							phase_d   = wavhp_pkg::PH_TAG;
						end
						wavhp_pkg::PH_TAG: begin
							cmd.store = wavhp_pkg::ST_TAG;
							phase_d   = wavhp_pkg::PH_CHAN;
						end
						wavhp_pkg::PH_CHAN: begin
							cmd.store = wavhp_pkg::ST_CHAN;
							phase_d   = wavhp_pkg::PH_RATE;
						end
						wavhp_pkg::PH_RATE: begin
							cmd.store = wavhp_pkg::ST_RATE;
							phase_d   = wavhp_pkg::PH_AVG;
						end
						wavhp_pkg::PH_ALIGN: begin
							cmd.store = wavhp_pkg::ST_ALIGN;
							phase_d   = wavhp_pkg::PH_BITS;
						end
						wavhp_pkg::PH_BITS: begin
							cmd.store = wavhp_pkg::ST_BITS;
							phase_d   = stat.fmt_ext ? wavhp_pkg::PH_CBSIZE :
								wavhp_pkg::PH_FIRST_ID;
						end
						wavhp_pkg::PH_CBSIZE: begin
							phase_d = stat.fmt_wavex ? wavhp_pkg::PH_VALID :
								wavhp_pkg::PH_FIRST_ID;
						end
						wavhp_pkg::PH_SUBFMT: begin
							cmd.store = wavhp_pkg::ST_SUBFMT;
							phase_d   = wavhp_pkg::PH_FIRST_ID;
						end
						wavhp_pkg::PH_FIRST_ID: begin
							if (stat.is_fact) begin
								cmd.store = wavhp_pkg::ST_FACT_SEEN;
								phase_d   = wavhp_pkg::PH_FACT_SIZE;
							end else if (stat.is_data) begin
								phase_d = wavhp_pkg::PH_DATA_SIZE;
							end else begin
								phase_d = wavhp_pkg::PH_CHUNK_SIZE;
							end
						end
						wavhp_pkg::PH_FACT_SIZE: begin
							cmd.store = wavhp_pkg::ST_FACT_SIZE;
							phase_d   = wavhp_pkg::PH_FACT_LEN;
						end
						wavhp_pkg::PH_FACT_LEN: begin
							if (stat.fact_long) begin
								cmd.store = wavhp_pkg::ST_SKIP_FACT;
								phase_d   = wavhp_pkg::PH_SKIP;
							end else begin
								phase_d = wavhp_pkg::PH_CHUNK_ID;
							end
						end
						wavhp_pkg::PH_CHUNK_ID: begin
							phase_d = stat.is_data ? wavhp_pkg::PH_DATA_SIZE :
								wavhp_pkg::PH_CHUNK_SIZE;
						end
						wavhp_pkg::PH_CHUNK_SIZE: begin
							if (stat.word_zero) begin
								phase_d = wavhp_pkg::PH_CHUNK_ID;
							end else begin
								cmd.store = wavhp_pkg::ST_SKIP_CHUNK;
								phase_d   = wavhp_pkg::PH_SKIP;
							end
						end
						wavhp_pkg::PH_DATA_SIZE: begin
							cmd.div_start = 1'b1;
							phase_d       = wavhp_pkg::PH_DONE;
						end
						default: begin
							phase_d = ph_base + 5'd1;
						end
					endcase
				end else begin
					idx_d = ix_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wavhp_pkg::PH_RIFF_ID;
			idx_q       <= '0;
			div_busy_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
			end else if (stat.div_done) begin
				div_busy_q <= 1'b0;
			end
			if (stat.div_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`WAVHP_ASSERT_IMP(a_start_idle, cmd.div_start, !div_busy_q && !out_valid_q, "divide started while busy")
	`WAVHP_ASSERT_IMP(a_done_busy, stat.div_done, div_busy_q, "divide done without a start")
	`WAVHP_ASSERT_IMP(a_result_from_div, $rose(out_valid_q), $past(div_busy_q), "result without divide")
	`WAVHP_ASSERT_ALWAYS(a_idx_range, idx_q < 5'd16, "field byte index out of range")

endmodule

`default_nettype wire
